/* rtl/core/szsg_pkg.sv */
// Package for the scan zone speed guard: register map, reset values,
// safety level codes and the shared configuration and result types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package szsg_pkg;

    // Elaboration defaults for the top-level parameters.
    localparam int DIST_BITS_DEF    = 16;
    localparam int MIN_VALID_MM_DEF = 20;

    // Register map, one 32-bit word per register.
    localparam int          NUM_REGS  = 8;
    localparam int          ADDR_BITS = 5;
    localparam logic [2:0] REG_FRONT_HALF   = 3'd0;
    localparam logic [2:0] REG_STOP_HALF    = 3'd1;
    localparam logic [2:0] REG_FRONT_STOP   = 3'd2;
    localparam logic [2:0] REG_REAR_STOP    = 3'd3;
    localparam logic [2:0] REG_FRONT_CAUT   = 3'd4;
    localparam logic [2:0] REG_REAR_CAUT    = 3'd5;
    localparam logic [2:0] REG_CAUT_SPEED   = 3'd6;
    localparam logic [2:0] REG_SENSOR_MAX   = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_FRONT_HALF = 16'd8192;
    localparam logic [15:0] RST_STOP_HALF  = 16'd4096;
    localparam logic [15:0] RST_FRONT_STOP = 16'd300;
    localparam logic [15:0] RST_REAR_STOP  = 16'd200;
    localparam logic [15:0] RST_FRONT_CAUT = 16'd800;
    localparam logic [15:0] RST_REAR_CAUT  = 16'd500;
    localparam logic [14:0] RST_CAUT_SPEED = 15'd200;
    localparam logic [15:0] RST_SENSOR_MAX = 16'd12000;

    // Safety level codes.
    localparam logic [1:0] LVL_NORMAL  = 2'd0;
    localparam logic [1:0] LVL_CAUTION = 2'd1;
    localparam logic [1:0] LVL_STOP    = 2'd2;
    localparam logic [1:0] LVL_ESTOP   = 2'd3;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] front_half_angle;
        logic [15:0] stop_half_angle;
        logic [15:0] front_stop_mm;
        logic [15:0] rear_stop_mm;
        logic [15:0] front_caution_mm;
        logic [15:0] rear_caution_mm;
        logic [14:0] caution_speed_mm_s;
        logic [15:0] sensor_max_mm;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        logic signed [15:0] linear;
        logic signed [15:0] angular;
        logic [1:0]         level;
        logic [15:0]        nearest_mm;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/szsg_eval.sv */
// Per-sample evaluation: sector classification, running minima update and
// the safety decision for the last sample of a scan.
// Depends on szsg_pkg for the configuration and result types.
`default_nettype none

module szsg_eval #(
    parameter int DIST_BITS    = szsg_pkg::DIST_BITS_DEF,
    parameter int MIN_VALID_MM = szsg_pkg::MIN_VALID_MM_DEF
) (
    input  szsg_pkg::cfg_t        cfg,
    input  logic [15:0]           range_mm,
    input  logic signed [15:0]    start_angle,
    input  logic signed [15:0]    angle_step,
    input  logic                  first_sample,
    input  logic signed [15:0]    req_linear,
    input  logic signed [15:0]    req_angular,
    input  logic                  estop,
    input  logic [DIST_BITS-1:0]  front_near,
    input  logic [DIST_BITS-1:0]  stop_min,
    input  logic [DIST_BITS-1:0]  rear_near,
    input  logic [15:0]           cur_angle,
    input  logic [15:0]           step_hold,
    output logic [DIST_BITS-1:0]  front_near_next,
    output logic [DIST_BITS-1:0]  stop_min_next,
    output logic [DIST_BITS-1:0]  rear_near_next,
    output logic [15:0]           cur_angle_next,
    output logic [15:0]           step_hold_next,
    output szsg_pkg::res_t        res
);
    import szsg_pkg::*;

    // Compare width covers both the 16-bit fields and the distance width.
    localparam int CW = (DIST_BITS > 16) ? DIST_BITS : 16;
    localparam logic [DIST_BITS-1:0] EMPTY     = {DIST_BITS{1'b1}};
    localparam logic [CW-1:0]        EMPTY_W   = CW'(EMPTY);
    localparam logic [15:0]          MIN_VALID = 16'(MIN_VALID_MM);

    // A minimum hits a threshold only when the sector is not empty.
    function automatic logic hits(input logic [DIST_BITS-1:0] m, input logic [15:0] limit);
        hits = (m != EMPTY) && (CW'(m) <= CW'(limit));
    endfunction

    logic [15:0]          angle_use;
    logic [16:0]          mag;
    logic                 in_front;
    logic                 in_stop;
    logic                 rd_ok;
    logic [CW-1:0]        rng_w;
    logic [DIST_BITS-1:0] rng_d;
    logic [DIST_BITS-1:0] front_base;
    logic [DIST_BITS-1:0] stop_base;
    logic [DIST_BITS-1:0] rear_base;
    logic [DIST_BITS-1:0] nearest;
    logic signed [16:0]   lin_w;
    logic signed [16:0]   lim_pos;
    logic signed [16:0]   lim_neg;
    logic signed [15:0]   lin_clamp;

    // Angle of this sample: restarted on the first sample, then advanced.
    always_comb
    begin
        angle_use      = first_sample ? start_angle : cur_angle;
        step_hold_next = first_sample ? angle_step : step_hold;
        cur_angle_next = angle_use + step_hold_next;
    end

    // Angle magnitude and sector membership; stop sector nests in front.
    always_comb
    begin
        mag      = angle_use[15] ? (17'd0 - {1'b1, angle_use}) : {1'b0, angle_use};
        in_front = mag <= {1'b0, cfg.front_half_angle};
        in_stop  = in_front && (mag <= {1'b0, cfg.stop_half_angle});
    end

    // Reading validity and saturation one below the empty code.
    always_comb
    begin
        rd_ok = (range_mm > MIN_VALID) && (range_mm < cfg.sensor_max_mm);
        rng_w = CW'(range_mm);
        if (rng_w >= EMPTY_W)
        begin
            rng_d = EMPTY - DIST_BITS'(1);
        end
        else
        begin
            rng_d = rng_w[DIST_BITS-1:0];
        end
    end

    // Running minima, cleared at the start of a scan.
    always_comb
    begin
        front_base = first_sample ? EMPTY : front_near;
        stop_base  = first_sample ? EMPTY : stop_min;
        rear_base  = first_sample ? EMPTY : rear_near;
        front_near_next = (rd_ok && in_front && (rng_d < front_base)) ? rng_d : front_base;
        stop_min_next   = (rd_ok && in_stop && (rng_d < stop_base)) ? rng_d : stop_base;
        rear_near_next  = (rd_ok && !in_front && (rng_d < rear_base)) ? rng_d : rear_base;
    end

    // Linear speed clamp for the caution level.
    always_comb
    begin
        lin_w   = {req_linear[15], req_linear};
        lim_pos = {2'b00, cfg.caution_speed_mm_s};
        lim_neg = 17'sd0 - lim_pos;
        if (lin_w > lim_pos)
        begin
            lin_clamp = lim_pos[15:0];
        end
        else if (lin_w < lim_neg)
        begin
            lin_clamp = lim_neg[15:0];
        end
        else
        begin
            lin_clamp = req_linear;
        end
    end

    // Safety decision from the minima after this sample.
    always_comb
    begin
        nearest = (front_near_next < rear_near_next) ? front_near_next : rear_near_next;
        res.linear     = '0;
        res.angular    = '0;
        res.nearest_mm = 16'(nearest);
        if (estop)
        begin
            res.level      = LVL_ESTOP;
            res.nearest_mm = '0;
        end
        else if (hits(stop_min_next, cfg.front_stop_mm) ||
                 hits(rear_near_next, cfg.rear_stop_mm))
        begin
            res.level = LVL_STOP;
        end
        else if (hits(front_near_next, cfg.front_caution_mm) ||
                 hits(rear_near_next, cfg.rear_caution_mm))
        begin
            res.level   = LVL_CAUTION;
            res.linear  = lin_clamp;
            res.angular = req_angular;
        end
        else
        begin
            res.level   = LVL_NORMAL;
            res.linear  = req_linear;
            res.angular = req_angular;
            if (nearest == EMPTY)
            begin
                res.nearest_mm = cfg.sensor_max_mm;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/scan_zone_speed_guard.sv */
// Scan zone speed guard top level: APB register file, input register,
// scan state registers and the result register.
// Depends on szsg_pkg and szsg_eval.
`default_nettype none

// One range sample is taken per clock while in_stall is low. A sample is
// captured in an input register and evaluated there against the sector
// minima, and a last sample's result is registered and presented on the output.
// Only samples flagged last_sample produce a result transaction; others just
// update the minima. The input stalls only when a last sample is waiting in
// the input register while the result register is still held by out_stall.
// Configuration registers sit at byte address 4*i and read back their field
// bits zero-extended; write them only while no scan is in flight.
module scan_zone_speed_guard #(
    parameter int DIST_BITS    = szsg_pkg::DIST_BITS_DEF,
    parameter int MIN_VALID_MM = szsg_pkg::MIN_VALID_MM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [szsg_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Sample channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     range_mm,
    input  logic signed [15:0]              start_angle,
    input  logic signed [15:0]              angle_step,
    input  logic                            first_sample,
    input  logic                            last_sample,
    input  logic signed [15:0]              req_linear,
    input  logic signed [15:0]              req_angular,
    input  logic                            estop,
    // Result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              out_linear,
    output logic signed [15:0]              out_angular,
    output logic [1:0]                      safety_level,
    output logic [15:0]                     nearest_mm
);
    import szsg_pkg::*;

    localparam logic [DIST_BITS-1:0] EMPTY = {DIST_BITS{1'b1}};

    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    logic                 s1_valid_reg;
    logic [15:0]          s1_range_reg;
    logic signed [15:0]   s1_start_reg;
    logic signed [15:0]   s1_step_reg;
    logic                 s1_first_reg;
    logic                 s1_last_reg;
    logic signed [15:0]   s1_lin_reg;
    logic signed [15:0]   s1_ang_reg;
    logic                 s1_estop_reg;

    logic [DIST_BITS-1:0] front_near_reg;
    logic [DIST_BITS-1:0] stop_min_reg;
    logic [DIST_BITS-1:0] rear_near_reg;
    logic [15:0]          cur_angle_reg;
    logic [15:0]          step_hold_reg;
    logic [DIST_BITS-1:0] front_near_next;
    logic [DIST_BITS-1:0] stop_min_next;
    logic [DIST_BITS-1:0] rear_near_next;
    logic [15:0]          cur_angle_next;
    logic [15:0]          step_hold_next;

    res_t                 res_next;
    res_t                 res_reg;
    logic                 out_valid_reg;

    logic                 out_free;
    logic                 proc;
    logic                 in_take;

    // Register file write and read-back.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_half_angle   <= RST_FRONT_HALF;
            cfg_reg.stop_half_angle    <= RST_STOP_HALF;
            cfg_reg.front_stop_mm      <= RST_FRONT_STOP;
            cfg_reg.rear_stop_mm       <= RST_REAR_STOP;
            cfg_reg.front_caution_mm   <= RST_FRONT_CAUT;
            cfg_reg.rear_caution_mm    <= RST_REAR_CAUT;
            cfg_reg.caution_speed_mm_s <= RST_CAUT_SPEED;
            cfg_reg.sensor_max_mm      <= RST_SENSOR_MAX;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FRONT_HALF: cfg_reg.front_half_angle   <= pwdata[15:0];
                REG_STOP_HALF:  cfg_reg.stop_half_angle    <= pwdata[15:0];
                REG_FRONT_STOP: cfg_reg.front_stop_mm      <= pwdata[15:0];
                REG_REAR_STOP:  cfg_reg.rear_stop_mm       <= pwdata[15:0];
                REG_FRONT_CAUT: cfg_reg.front_caution_mm   <= pwdata[15:0];
                REG_REAR_CAUT:  cfg_reg.rear_caution_mm    <= pwdata[15:0];
                REG_CAUT_SPEED: cfg_reg.caution_speed_mm_s <= pwdata[14:0];
                REG_SENSOR_MAX: cfg_reg.sensor_max_mm      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRONT_HALF: prdata = {16'd0, cfg_reg.front_half_angle};
            REG_STOP_HALF:  prdata = {16'd0, cfg_reg.stop_half_angle};
            REG_FRONT_STOP: prdata = {16'd0, cfg_reg.front_stop_mm};
            REG_REAR_STOP:  prdata = {16'd0, cfg_reg.rear_stop_mm};
            REG_FRONT_CAUT: prdata = {16'd0, cfg_reg.front_caution_mm};
            REG_REAR_CAUT:  prdata = {16'd0, cfg_reg.rear_caution_mm};
            REG_CAUT_SPEED: prdata = {17'd0, cfg_reg.caution_speed_mm_s};
            REG_SENSOR_MAX: prdata = {16'd0, cfg_reg.sensor_max_mm};
            default:        prdata = '0;
        endcase
    end

    // Flow control: a sample in the input register is evaluated unless it
    // ends a scan and the result register cannot take its transaction.
    assign out_free = !out_valid_reg || !out_stall;
    assign proc     = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_range_reg <= range_mm;
            s1_start_reg <= start_angle;
            s1_step_reg  <= angle_step;
            s1_first_reg <= first_sample;
            s1_last_reg  <= last_sample;
            s1_lin_reg   <= req_linear;
            s1_ang_reg   <= req_angular;
            s1_estop_reg <= estop;
        end
    end

    // Sample evaluation.
    szsg_eval #(
        .DIST_BITS    (DIST_BITS),
        .MIN_VALID_MM (MIN_VALID_MM)
    ) u_eval (
        .cfg             (cfg_reg),
        .range_mm        (s1_range_reg),
        .start_angle     (s1_start_reg),
        .angle_step      (s1_step_reg),
        .first_sample    (s1_first_reg),
        .req_linear      (s1_lin_reg),
        .req_angular     (s1_ang_reg),
        .estop           (s1_estop_reg),
        .front_near      (front_near_reg),
        .stop_min        (stop_min_reg),
        .rear_near       (rear_near_reg),
        .cur_angle       (cur_angle_reg),
        .step_hold       (step_hold_reg),
        .front_near_next (front_near_next),
        .stop_min_next   (stop_min_next),
        .rear_near_next  (rear_near_next),
        .cur_angle_next  (cur_angle_next),
        .step_hold_next  (step_hold_next),
        .res             (res_next)
    );

    // Scan state: sector minima and the angle tracker.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_near_reg <= EMPTY;
            stop_min_reg   <= EMPTY;
            rear_near_reg  <= EMPTY;
            cur_angle_reg  <= '0;
            step_hold_reg  <= '0;
        end
        else if (proc)
        begin
            front_near_reg <= front_near_next;
            stop_min_reg   <= stop_min_next;
            rear_near_reg  <= rear_near_next;
            cur_angle_reg  <= cur_angle_next;
            step_hold_reg  <= step_hold_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && s1_last_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_linear   = res_reg.linear;
    assign out_angular  = res_reg.angular;
    assign safety_level = res_reg.level;
    assign nearest_mm   = res_reg.nearest_mm;

    // The stop sector is a subset of the front sector, so its minimum
    // can never be below the front minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_min_reg >= front_near_reg)
        else $error("stop sector minimum below front minimum");

    // An emergency stop result always commands zero motion and distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.level == LVL_ESTOP) |->
            (res_reg.linear == 16'sd0) && (res_reg.angular == 16'sd0) &&
            (res_reg.nearest_mm == 16'd0))
        else $error("emergency stop result carries motion");

    // A caution result keeps the linear speed within the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.level == LVL_CAUTION) |->
            ($signed({res_reg.linear[15], res_reg.linear}) <=
                 $signed({2'b00, cfg_reg.caution_speed_mm_s})) &&
            ($signed({res_reg.linear[15], res_reg.linear}) >=
                 -$signed({2'b00, cfg_reg.caution_speed_mm_s})))
        else $error("caution result exceeds speed limit");

    // A stall holds a scan-ending sample in the input register untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && s1_last_reg)
        else $error("stalled sample lost from the input register");

endmodule

`default_nettype wire

/* tb/tb_scan_zone_speed_guard.sv */
// Self-checking testbench for the scan zone speed guard: a scoreboard class
// predicts each safety command from the accepted samples and checks the results.
// Depends on szsg_pkg and the scan_zone_speed_guard top level.
`timescale 1ns / 100ps

localparam logic [15:0] EMPTY_MM      = 16'hFFFF;
localparam int          VALID_MIN_MM  = szsg_pkg::MIN_VALID_MM_DEF;

// One sample transaction as the sender drives it.
typedef struct {
    logic [15:0]        range_mm;
    logic signed [15:0] start_angle;
    logic signed [15:0] angle_step;
    logic               first_sample;
    logic               last_sample;
    logic signed [15:0] req_linear;
    logic signed [15:0] req_angular;
    logic               estop;
} sample_t;

// Tracks the sector minima and scan angle, and keeps the safety commands
// that are still owed by the block.
class zone_guard_scoreboard;
    szsg_pkg::cfg_t     cfg;
    logic [15:0]        front_near;
    logic [15:0]        stop_min;
    logic [15:0]        rear_near;
    logic [15:0]        cur_angle;
    logic [15:0]        step_hold;
    szsg_pkg::res_t     pending_cmds[$];
    int                 errors;
    int                 n_samples;
    int                 n_results;
    int                 level_count[4];

    function new();
        cfg.front_half_angle   = szsg_pkg::RST_FRONT_HALF;
        cfg.stop_half_angle    = szsg_pkg::RST_STOP_HALF;
        cfg.front_stop_mm      = szsg_pkg::RST_FRONT_STOP;
        cfg.rear_stop_mm       = szsg_pkg::RST_REAR_STOP;
        cfg.front_caution_mm   = szsg_pkg::RST_FRONT_CAUT;
        cfg.rear_caution_mm    = szsg_pkg::RST_REAR_CAUT;
        cfg.caution_speed_mm_s = szsg_pkg::RST_CAUT_SPEED;
        cfg.sensor_max_mm      = szsg_pkg::RST_SENSOR_MAX;
        front_near = EMPTY_MM;
        stop_min   = EMPTY_MM;
        rear_near  = EMPTY_MM;
        cur_angle = '0;
        step_hold = '0;
        errors    = 0;
        n_samples = 0;
        n_results = 0;
        foreach (level_count[i])
            level_count[i] = 0;
    endfunction

    function void report(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function int pending();
        return pending_cmds.size();
    endfunction

    // Mirror of a register write on the configuration port.
    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            szsg_pkg::REG_FRONT_HALF: cfg.front_half_angle   = value[15:0];
            szsg_pkg::REG_STOP_HALF:  cfg.stop_half_angle    = value[15:0];
            szsg_pkg::REG_FRONT_STOP: cfg.front_stop_mm      = value[15:0];
            szsg_pkg::REG_REAR_STOP:  cfg.rear_stop_mm       = value[15:0];
            szsg_pkg::REG_FRONT_CAUT: cfg.front_caution_mm   = value[15:0];
            szsg_pkg::REG_REAR_CAUT:  cfg.rear_caution_mm    = value[15:0];
            szsg_pkg::REG_CAUT_SPEED: cfg.caution_speed_mm_s = value[14:0];
            szsg_pkg::REG_SENSOR_MAX: cfg.sensor_max_mm      = value[15:0];
            default: ;
        endcase
    endfunction

    // A stored minimum saturates one below the empty code.
    function logic [15:0] keep_min(logic [15:0] cur, logic [15:0] r);
        if (r >= EMPTY_MM)
            r = EMPTY_MM - 16'd1;
        return (r < cur) ? r : cur;
    endfunction

    // An empty sector never meets a threshold.
    function bit hits(logic [15:0] m, logic [15:0] limit);
        return (m != EMPTY_MM) && (m <= limit);
    endfunction

    // Update the scan state with one accepted sample and queue the command
    // that a last sample produces.
    function void take_sample(sample_t s);
        int             a;
        int             mag;
        int             lim;
        int             lin;
        int             ang;
        int             rl;
        logic [15:0]    closest;
        szsg_pkg::res_t cmd;

        n_samples++;
        if (s.first_sample)
        begin
            front_near = EMPTY_MM;
            stop_min   = EMPTY_MM;
            rear_near  = EMPTY_MM;
            cur_angle = s.start_angle;
            step_hold = s.angle_step;
        end

        // Sector sort on the angle magnitude of the current sample.
        if (s.range_mm > VALID_MIN_MM && s.range_mm < cfg.sensor_max_mm)
        begin
            a   = $signed(cur_angle);
            mag = (a < 0) ? -a : a;
            if (mag <= int'(cfg.front_half_angle))
            begin
                front_near = keep_min(front_near, s.range_mm);
                if (mag <= int'(cfg.stop_half_angle))
                    stop_min = keep_min(stop_min, s.range_mm);
            end
            else
                rear_near = keep_min(rear_near, s.range_mm);
        end
        cur_angle = cur_angle + step_hold;

        if (!s.last_sample)
            return;

        // Pick the safety level, most severe first.
        closest = (front_near < rear_near) ? front_near : rear_near;
        lin = 0;
        ang = 0;
        if (s.estop)
        begin
            cmd.level = szsg_pkg::LVL_ESTOP;
            closest   = '0;
        end
        else if (hits(stop_min, cfg.front_stop_mm) || hits(rear_near, cfg.rear_stop_mm))
            cmd.level = szsg_pkg::LVL_STOP;
        else if (hits(front_near, cfg.front_caution_mm) ||
                 hits(rear_near, cfg.rear_caution_mm))
        begin
            cmd.level = szsg_pkg::LVL_CAUTION;
            lim = int'(cfg.caution_speed_mm_s);
            rl  = s.req_linear;
            lin = (rl > lim) ? lim : ((rl < -lim) ? -lim : rl);
            ang = s.req_angular;
        end
        else
        begin
            cmd.level = szsg_pkg::LVL_NORMAL;
            lin = s.req_linear;
            ang = s.req_angular;
            if (closest == EMPTY_MM)
                closest = cfg.sensor_max_mm;
        end
        cmd.linear     = lin[15:0];
        cmd.angular    = ang[15:0];
        cmd.nearest_mm = closest;
        pending_cmds.push_back(cmd);
    endfunction

    // Compare one result transaction with the oldest queued command.
    function void check_command(szsg_pkg::res_t got);
        szsg_pkg::res_t exp;

        n_results++;
        if (pending_cmds.size() == 0)
        begin
            report($sformatf("result %0d arrived with no command pending", n_results));
            return;
        end
        exp = pending_cmds.pop_front();
        level_count[int'(exp.level)]++;
        if ($isunknown(got))
        begin
            report($sformatf("result %0d has unknown bits", n_results));
            return;
        end
        if (got.linear !== exp.linear)
            report($sformatf("result %0d out_linear: got %0d, expected %0d",
                             n_results, got.linear, exp.linear));
        if (got.angular !== exp.angular)
            report($sformatf("result %0d out_angular: got %0d, expected %0d",
                             n_results, got.angular, exp.angular));
        if (got.level !== exp.level)
            report($sformatf("result %0d safety_level: got %0d, expected %0d",
                             n_results, got.level, exp.level));
        if (got.nearest_mm !== exp.nearest_mm)
            report($sformatf("result %0d nearest_mm: got %0d, expected %0d",
                             n_results, got.nearest_mm, exp.nearest_mm));
    endfunction
endclass

module tb_scan_zone_speed_guard;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int NUM_PHASES     = 9;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [szsg_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [15:0]                    range_mm;
    logic signed [15:0]             start_angle;
    logic signed [15:0]             angle_step;
    logic                           first_sample;
    logic                           last_sample;
    logic signed [15:0]             req_linear;
    logic signed [15:0]             req_angular;
    logic                           estop;
    logic                           out_valid;
    logic                           out_stall;
    logic signed [15:0]             out_linear;
    logic signed [15:0]             out_angular;
    logic [1:0]                     safety_level;
    logic [15:0]                    nearest_mm;

    zone_guard_scoreboard sb;
    szsg_pkg::res_t       seen_cmd;
    bit                   quiet;
    bit                   hold_req;
    int                   items_sent;
    int                   n_settings;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    scan_zone_speed_guard u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .range_mm     (range_mm),
        .start_angle  (start_angle),
        .angle_step   (angle_step),
        .first_sample (first_sample),
        .last_sample  (last_sample),
        .req_linear   (req_linear),
        .req_angular  (req_angular),
        .estop        (estop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_linear   (out_linear),
        .out_angular  (out_angular),
        .safety_level (safety_level),
        .nearest_mm   (nearest_mm)
    );

    // Result monitor: every accepted result transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen_cmd.linear     = out_linear;
            seen_cmd.angular    = out_angular;
            seen_cmd.level      = safety_level;
            seen_cmd.nearest_mm = nearest_mm;
            sb.check_command(seen_cmd);
        end
    end

    // Mostly short gaps, now and then a long one.
    function int rand_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        int hold_left;
        int gap_left;

        hold_left = 0;
        gap_left  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (gap_left > 0 && !quiet)
            begin
                out_stall <= 1'b1;
                gap_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                gap_left = 0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = rand_gap();
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial
    begin : watchdog
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(szsg_pkg::cfg_t c);
        apb_write(szsg_pkg::REG_FRONT_HALF, {16'd0, c.front_half_angle});
        apb_write(szsg_pkg::REG_STOP_HALF,  {16'd0, c.stop_half_angle});
        apb_write(szsg_pkg::REG_FRONT_STOP, {16'd0, c.front_stop_mm});
        apb_write(szsg_pkg::REG_REAR_STOP,  {16'd0, c.rear_stop_mm});
        apb_write(szsg_pkg::REG_FRONT_CAUT, {16'd0, c.front_caution_mm});
        apb_write(szsg_pkg::REG_REAR_CAUT,  {16'd0, c.rear_caution_mm});
        apb_write(szsg_pkg::REG_CAUT_SPEED, {17'd0, c.caution_speed_mm_s});
        apb_write(szsg_pkg::REG_SENSOR_MAX, {16'd0, c.sensor_max_mm});
        n_settings++;
    endtask

    // Register settings per phase: random ones and the extremes.
    function szsg_pkg::cfg_t phase_config(int ph);
        szsg_pkg::cfg_t c;

        c.front_half_angle   = 16'($urandom_range(0, 32768));
        c.stop_half_angle    = 16'($urandom_range(0, 1) ? $urandom_range(0, c.front_half_angle)
                                                        : $urandom_range(0, 32768));
        c.front_stop_mm      = 16'($urandom_range(0, 1500));
        c.rear_stop_mm       = 16'($urandom_range(0, 1500));
        c.front_caution_mm   = c.front_stop_mm + 16'($urandom_range(0, 3000));
        c.rear_caution_mm    = c.rear_stop_mm + 16'($urandom_range(0, 3000));
        c.caution_speed_mm_s = 15'($urandom_range(0, 32767));
        c.sensor_max_mm      = 16'($urandom_range(1000, 20000));
        case (ph)
            3:
            begin
                // Everything at its top value.
                c.front_half_angle   = 16'd32768;
                c.stop_half_angle    = 16'd32768;
                c.front_stop_mm      = 16'd65534;
                c.rear_stop_mm       = 16'd65534;
                c.front_caution_mm   = 16'd65534;
                c.rear_caution_mm    = 16'd65534;
                c.caution_speed_mm_s = 15'd32767;
                c.sensor_max_mm      = 16'd65535;
            end
            4:
            begin
                // Any valid reading gives caution with a zero speed limit.
                c.front_half_angle   = 16'd32768;
                c.stop_half_angle    = 16'd0;
                c.front_stop_mm      = 16'd0;
                c.rear_stop_mm       = 16'd0;
                c.front_caution_mm   = 16'd65534;
                c.rear_caution_mm    = 16'd65534;
                c.caution_speed_mm_s = 15'd0;
                c.sensor_max_mm      = 16'd65535;
            end
            5:
            begin
                // Everything at its bottom value; no reading can count.
                c.front_half_angle   = 16'd0;
                c.stop_half_angle    = 16'd0;
                c.front_stop_mm      = 16'd0;
                c.rear_stop_mm       = 16'd0;
                c.front_caution_mm   = 16'd0;
                c.rear_caution_mm    = 16'd0;
                c.caution_speed_mm_s = 15'd0;
                c.sensor_max_mm      = 16'd21;
            end
            6:
            begin
                // Stop sector set wider than the front sector.
                c.front_half_angle = 16'd4000;
                c.stop_half_angle  = 16'd30000;
            end
            default: ;
        endcase
        return c;
    endfunction

    function int phase_items(int ph);
        case (ph)
            1:       return 250;
            2:       return 220;
            3:       return 150;
            4:       return 150;
            5:       return 80;
            default: return 200;
        endcase
    endfunction

    function logic [15:0] clamp16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function logic [15:0] around(int base);
        return clamp16(base + int'($urandom_range(0, 4)) - 2);
    endfunction

    // Ranges aimed at the validity bounds and the current thresholds.
    function logic [15:0] pick_range();
        case ($urandom_range(0, 11))
            0:       return 16'($urandom_range(0, 25));
            1:       return around(sb.cfg.front_stop_mm);
            2:       return around(sb.cfg.rear_stop_mm);
            3:       return around(sb.cfg.front_caution_mm);
            4:       return around(sb.cfg.rear_caution_mm);
            5:       return around(sb.cfg.sensor_max_mm);
            6:       return 16'($urandom);
            7:       return 16'hFFFF - 16'($urandom_range(0, 1));
            default: return 16'($urandom_range(21, 3000));
        endcase
    endfunction

    function logic [15:0] pick_speed();
        case ($urandom_range(0, 3))
            0:       return around(sb.cfg.caution_speed_mm_s);
            1:       return -around(sb.cfg.caution_speed_mm_s);
            2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid for a gap; range and flags carry noise meanwhile.
    task automatic idle_input(int cycles);
        @(negedge clk);
        in_valid     <= 1'b0;
        range_mm     <= 16'($urandom);
        first_sample <= 1'($urandom);
        last_sample  <= 1'($urandom);
        estop        <= 1'($urandom);
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Offer one sample transaction and hold it until it is accepted.
    task automatic send_sample(sample_t s);
        int gap;

        @(negedge clk);
        in_valid     <= 1'b1;
        range_mm     <= s.range_mm;
        start_angle  <= s.start_angle;
        angle_step   <= s.angle_step;
        first_sample <= s.first_sample;
        last_sample  <= s.last_sample;
        req_linear   <= s.req_linear;
        req_angular  <= s.req_angular;
        estop        <= s.estop;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.take_sample(s);
        items_sent++;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? rand_gap() : 0;
        if (gap > 0)
            idle_input(gap);
    endtask

    task automatic directed(int rng, bit first, bit last, int start, int step,
                            int lin, int ang, bit stop_now);
        sample_t s;

        s.range_mm     = rng[15:0];
        s.first_sample = first;
        s.last_sample  = last;
        s.start_angle  = start[15:0];
        s.angle_step   = step[15:0];
        s.req_linear   = lin[15:0];
        s.req_angular  = ang[15:0];
        s.estop        = stop_now;
        send_sample(s);
    endtask

    // One scan with random content; a few lack their first or last flag,
    // and now and then a lone sample with random flags goes in instead.
    task automatic random_scan(bit short_scan);
        sample_t            s;
        int                 n;
        bit                 with_first;
        bit                 with_last;
        logic signed [15:0] st;
        logic signed [15:0] stp;

        if (!short_scan && $urandom_range(0, 19) == 0)
        begin
            s.range_mm     = 16'($urandom);
            s.start_angle  = 16'($urandom);
            s.angle_step   = 16'($urandom);
            s.first_sample = 1'($urandom);
            s.last_sample  = 1'($urandom);
            s.req_linear   = 16'($urandom);
            s.req_angular  = 16'($urandom);
            s.estop        = 1'($urandom);
            send_sample(s);
            return;
        end
        if (short_scan)
            n = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(1, 8);
        with_first = short_scan || ($urandom_range(0, 9) != 0);
        with_last  = short_scan || ($urandom_range(0, 11) != 0);
        st  = 16'($urandom);
        stp = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 4000)) - 2000);
        for (int i = 0; i < n; i++)
        begin
            s.range_mm     = pick_range();
            s.start_angle  = (i == 0) ? st : 16'($urandom);
            s.angle_step   = (i == 0) ? stp : 16'($urandom);
            s.first_sample = with_first && (i == 0);
            s.last_sample  = with_last && (i == n - 1);
            s.req_linear   = pick_speed();
            s.req_angular  = 16'($urandom);
            s.estop        = ($urandom_range(0, 9) == 0);
            send_sample(s);
        end
    endtask

    // Stop offering samples and wait until every command has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int target;
        int phase_start;

        sb           = new();
        quiet        = 1'b1;
        hold_req     = 1'b0;
        items_sent   = 0;
        n_settings   = 1;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        range_mm     = '0;
        start_angle  = '0;
        angle_step   = '0;
        first_sample = 1'b0;
        last_sample  = 1'b0;
        req_linear   = '0;
        req_angular  = '0;
        estop        = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed scans on the reset settings.
        // A last sample straight after reset, with no first sample.
        directed(100, 0, 1, 0, 0, 1000, 50, 0);
        // Caution clamps the linear speed at both ends.
        directed(500, 1, 1, 0, 0, 32767, -32768, 0);
        directed(700, 1, 1, 6000, 0, -32768, 32767, 0);
        // Validity bounds of the range reading.
        directed(20, 1, 1, 0, 0, 32767, -32768, 0);
        directed(21, 1, 1, 0, 0, 5, 5, 0);
        directed(11999, 1, 1, 0, 0, -5, -5, 0);
        directed(12000, 1, 1, 0, 0, 300, 300, 0);
        directed(65535, 1, 1, 0, 0, -300, 1, 0);
        directed(0, 1, 1, 0, 0, 1, -1, 0);
        // Most negative angle lies in the rear sector.
        directed(150, 1, 1, -32768, 0, 100, 100, 0);
        directed(400, 1, 1, 16384, 0, 900, -900, 0);
        // Emergency stop counts on the last sample only.
        directed(100, 1, 0, 0, 100, 0, 0, 1);
        directed(5000, 0, 1, 0, 0, 250, 250, 0);
        directed(1000, 1, 0, 32000, 1000, 0, 0, 0);
        directed(90, 0, 0, 0, 0, 0, 0, 0);
        directed(3000, 0, 1, 0, 0, 400, 400, 1);
        // Angle wrap across the rear.
        directed(250, 1, 0, 32000, 1000, 0, 0, 0);
        directed(600, 0, 0, 0, 0, 0, 0, 0);
        directed(900, 0, 1, 0, 0, -1000, 7, 0);
        // Sector edges.
        directed(290, 1, 1, 4096, 0, 10, 10, 0);
        directed(290, 1, 1, -4097, 0, 10, 10, 0);
        directed(600, 1, 1, 8192, 0, 10, 10, 0);
        directed(450, 1, 1, 8193, 0, 10, 10, 0);
        // A sample after a last sample with no new first sample.
        directed(5000, 0, 1, 0, 0, 20, 20, 0);

        // Random phases; each after the first writes its own register setting.
        for (int ph = 1; ph <= NUM_PHASES; ph++)
        begin
            settle();
            if (ph > 1)
                write_config(phase_config(ph));
            quiet       = (ph == 2);
            phase_start = items_sent;
            target      = items_sent + phase_items(ph);
            if (ph == 1)
                hold_req = 1'b1;
            while (items_sent < target)
                random_scan(ph == 1 && items_sent < phase_start + 80);
        end
        settle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d commands never arrived", sb.pending()));
        $display("Run covered %0d samples and %0d commands over %0d register settings",
                 sb.n_samples, sb.n_results, n_settings);
        $display("Levels seen: normal %0d, caution %0d, stop %0d, emergency %0d",
                 sb.level_count[szsg_pkg::LVL_NORMAL], sb.level_count[szsg_pkg::LVL_CAUTION],
                 sb.level_count[szsg_pkg::LVL_STOP], sb.level_count[szsg_pkg::LVL_ESTOP]);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/szsg_pkg.sv
rtl/core/szsg_eval.sv
rtl/core/scan_zone_speed_guard.sv
tb/tb_scan_zone_speed_guard.sv
